### rtl/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types and codes for the indexed insert/remove array unit.
// ----------------------------------------------------------------------------
package iira_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 7;
	localparam int ST_W   = 2;

	typedef enum logic [2:0] {
		KIND_READ   = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_INSERT = 3'd2,
		KIND_REMOVE = 3'd3,
		KIND_APPEND = 3'd4
	} kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

### rtl/indexed_insert_remove_array_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_unit
// The result strobe (done) is registered and rises in the cycle after the start transfer.
// Throughput: one request per cycle; the whole row of cells shifts together.
// busy stays low; the receiver cannot stall, each result shows for one cycle.
// Reset clears the fill count and result strobe; slot contents are undefined.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array_unit
	import iira_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                kind,
	input  logic [IDX_W-1:0]          index,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      done,
	output logic signed [DATA_W-1:0]  read_value,
	output logic [ST_W-1:0]           status,
	output logic [IDX_W-1:0]          count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [AW-1:0] DEPTH_W = AW'(DEPTH);

	logic [CW-1:0]            fill_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] read_value_q;
	status_t                  status_q;
	logic [IDX_W-1:0]         count_q;

	logic [AW-1:0]            fill_w;
	logic [AW-1:0]            idx_w;
	logic [AW-1:0]            idx_eff;
	logic                     full;
	status_t                  st_c;
	cell_ctl_t                ctl;
	logic [AW-1:0]            fill_nxt;
	logic                     rd_en;
	logic signed [DATA_W-1:0] rd_or;

	logic signed [DATA_W-1:0] slot_a [DEPTH];
	logic signed [DATA_W-1:0] rd_a   [DEPTH];

	assign fill_w = AW'(fill_q);
	assign idx_w  = AW'(index);
	assign full   = fill_w == DEPTH_W;

	always_comb begin
		st_c      = ST_DONE;
		ctl.op    = CELL_HOLD;
		ctl.value = value;
		idx_eff   = idx_w;
		fill_nxt  = fill_w;
		rd_en     = 1'b0;
		unique case (kind)
			KIND_READ: begin
				if (idx_w < fill_w) rd_en = 1'b1;
				else st_c = ST_RANGE;
			end
			KIND_WRITE: begin
				if (idx_w < fill_w) ctl.op = CELL_WRITE;
				else st_c = ST_RANGE;
			end
			KIND_INSERT: begin
				if (idx_w > fill_w) st_c = ST_RANGE;
				else if (full) st_c = ST_FULL;
				else begin
					ctl.op   = CELL_INSERT;
					fill_nxt = fill_w + 1'b1;
				end
			end
			KIND_APPEND: begin
				idx_eff = fill_w;
				if (full) st_c = ST_FULL;
				else begin
					ctl.op   = CELL_INSERT;
					fill_nxt = fill_w + 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (idx_w < fill_w) begin
					ctl.op   = CELL_REMOVE;
					fill_nxt = fill_w - 1'b1;
				end else st_c = ST_RANGE;
			end
			default: begin
			end
		endcase
		if (!start) ctl.op = CELL_HOLD;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] lower_n;
		logic signed [DATA_W-1:0] upper_n;
		if (i == 0) begin : g_first
			assign lower_n = '0;
		end else begin : g_mid_lo
			assign lower_n = slot_a[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper_n = '0;
		end else begin : g_mid_hi
			assign upper_n = slot_a[i+1];
		end
		iira_cell #(
			.POS (i),
			.AW  (AW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (idx_eff),
			.fill  (fill_w),
			.lower (lower_n),
			.upper (upper_n),
			.slot  (slot_a[i]),
			.rd    (rd_a[i])
		);
	end

	// only the addressed cell drives a nonzero word
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) rd_or = rd_or | rd_a[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) fill_q <= CW'(fill_nxt);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			read_value_q <= rd_en ? rd_or : '0;
			status_q     <= st_c;
			count_q      <= IDX_W'(fill_nxt);
		end
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;

endmodule

### rtl/iira_cell.sv
// ----------------------------------------------------------------------------
// iira_cell
// One list slot. Loads the broadcast word, its lower neighbor (insert) or
// its upper neighbor (remove), and drives its word when it is addressed.
// ----------------------------------------------------------------------------
module iira_cell
	import iira_pkg::*;
#(
	parameter int POS = 0,
	parameter int AW  = 7
) (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic [AW-1:0]             idx,
	input  logic [AW-1:0]             fill,
	input  logic signed [DATA_W-1:0]  lower,
	input  logic signed [DATA_W-1:0]  upper,
	output logic signed [DATA_W-1:0]  slot,
	output logic signed [DATA_W-1:0]  rd
);

	localparam logic [AW:0] POS_W = (AW+1)'(POS);

	logic signed [DATA_W-1:0] slot_q;
	logic                     at_idx;
	logic                     above_idx;
	logic                     is_last;
	logic                     below_last;

	assign at_idx     = POS_W == {1'b0, idx};
	assign above_idx  = POS_W > {1'b0, idx};
	assign is_last    = (POS_W + 1'b1) == {1'b0, fill};
	assign below_last = (POS_W + 1'b1) < {1'b0, fill};

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_WRITE: begin
				if (at_idx) slot_q <= ctl.value;
			end
			CELL_INSERT: begin
				if (at_idx) slot_q <= ctl.value;
				else if (above_idx) slot_q <= lower;
			end
			CELL_REMOVE: begin
				// slot that drops out of use is cleared
				if ((at_idx || above_idx) && below_last) slot_q <= upper;
				else if (is_last) slot_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign slot = slot_q;
	assign rd   = at_idx ? slot_q : '0;

endmodule

### test/indexed_insert_remove_array_unit_test.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_unit_test
// Self-checking bench for the indexed insert/remove array unit. A shadow copy
// of the list predicts every result. Directed requests cover the empty and
// boundary cases. Random phases then grow the list, mix operations and shrink
// it, and include rejects on a full list and out-of-range indices.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array_unit_test
	import iira_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 1370;
	localparam int BLOCK_ITEMS  = 125;
	localparam int QUIET_LIMIT  = 200;
	localparam int MAX_PRINTS   = 40;

	// kinds the block treats as no-ops
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		status_t                  status;
		logic [IDX_W-1:0]         count;
	} list_result_t;

	class list_shadow;
		logic signed [DATA_W-1:0] slots [DEPTH];
		int                       fill;
		list_result_t             awaited_results [$];
		int                       errors;
		int                       results_seen;
		int                       kind_hits [8];
		int                       full_rejects;
		int                       range_rejects;
		int                       peak_fill;

		function new();
			foreach (slots[i]) slots[i] = '0;
			foreach (kind_hits[i]) kind_hits[i] = 0;
			fill          = 0;
			errors        = 0;
			results_seen  = 0;
			full_rejects  = 0;
			range_rejects = 0;
			peak_fill     = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		// apply one accepted request to the shadow list and queue its result
		function void note_request(logic [2:0] op, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] val);
			list_result_t r;
			int pos;
			r.read_value = '0;
			r.status     = ST_DONE;
			pos          = idx;
			kind_hits[op]++;
			case (op)
			KIND_READ: begin
				if (pos < fill) r.read_value = slots[pos];
				else r.status = ST_RANGE;
			end
			KIND_WRITE: begin
				if (pos < fill) slots[pos] = val;
				else r.status = ST_RANGE;
			end
			KIND_INSERT, KIND_APPEND: begin
				if (op == KIND_APPEND) pos = fill;
				if (pos > fill) begin
					r.status = ST_RANGE;
				end else if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int j = fill; j > pos; j--) slots[j] = slots[j-1];
					slots[pos] = val;
					fill++;
				end
			end
			KIND_REMOVE: begin
				if (pos < fill) begin
					for (int j = pos; j + 1 < fill; j++) slots[j] = slots[j+1];
					slots[fill-1] = '0;
					fill--;
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: ;
			endcase
			if (r.status == ST_FULL) full_rejects++;
			if (r.status == ST_RANGE) range_rejects++;
			if (fill > peak_fill) peak_fill = fill;
			r.count = IDX_W'(fill);
			awaited_results.push_back(r);
		endfunction

		task check_result(logic signed [DATA_W-1:0] rd, logic [ST_W-1:0] st,
				logic [IDX_W-1:0] cnt);
			list_result_t e;
			results_seen++;
			if (awaited_results.size() == 0) begin
				report("result strobe with no request outstanding");
			end else begin
				e = awaited_results.pop_front();
				if (rd !== e.read_value)
					report($sformatf("read_value %h, predicted %h", rd, e.read_value));
				if (st !== e.status)
					report($sformatf("status %0d, predicted %0d", st, e.status));
				if (cnt !== e.count)
					report($sformatf("count %0d, predicted %0d", cnt, e.count));
			end
		endtask
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic [2:0]               kind   = '0;
	logic [IDX_W-1:0]         index  = '0;
	logic signed [DATA_W-1:0] value  = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] read_value;
	logic [ST_W-1:0]          status;
	logic [IDX_W-1:0]         count;

	list_shadow shadow = new();
	int         quiet_cycles = 0;

	indexed_insert_remove_array_unit #(
		.DEPTH(DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.index     (index),
		.value     (value),
		.done      (done),
		.read_value(read_value),
		.status    (status),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// pre-edge values: the result shown in the cycle that this edge ends
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if (done) begin
				shadow.check_result(read_value, status, count);
				moved = 1'b1;
			end
			if (start && !busy) begin
				shadow.note_request(kind, index, value);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("indexed_insert_remove_array_unit regression: fail");
		$finish;
	end

	task automatic issue(logic [2:0] op, logic [IDX_W-1:0] idx,
			logic signed [DATA_W-1:0] val);
		start <= 1'b1;
		kind  <= op;
		index <= idx;
		value <= val;
		do @(posedge clk); while (busy);
	endtask

	// sender gap; fields carry junk while start is low
	task automatic pause(int cycles);
		start <= 1'b0;
		kind  <= 3'($urandom);
		index <= IDX_W'($urandom);
		value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		issue(KIND_READ,   7'd0,   32'sd0);
		issue(KIND_WRITE,  7'd0,   32'sd1);
		issue(KIND_REMOVE, 7'd0,   32'sd0);
		issue(KIND_INSERT, 7'd1,   32'sd5);
		issue(KIND_INSERT, 7'd0,   32'sh7FFF_FFFF);
		issue(KIND_APPEND, 7'd127, 32'sh8000_0000);
		issue(KIND_INSERT, 7'd2,   -32'sd1);
		issue(KIND_INSERT, 7'd1,   32'sh5A5A_A5A5);
		for (int i = 0; i < 5; i++) issue(KIND_READ, IDX_W'(i), 32'sd0);
		issue(KIND_WRITE,  7'd3,   32'sd0);
		issue(KIND_WRITE,  7'd127, 32'sh1234_5678);
		issue(KIND_REMOVE, 7'd127, 32'sd0);
		issue(KIND_INSERT, 7'd127, 32'sh0F0F_0F0F);
		issue(KIND_UNUSED_FIRST,      7'd127, -32'sd1);
		issue(KIND_UNUSED_FIRST + 3'd1, 7'd0, 32'sh8000_0000);
		issue(KIND_UNUSED_LAST,       7'd64, 32'sh7FFF_FFFF);
		issue(KIND_REMOVE, 7'd0,   32'sd0);
		issue(KIND_REMOVE, 7'd2,   32'sd0);
		issue(KIND_READ,   7'd0,   32'sd0);
		issue(KIND_READ,   7'd1,   32'sd0);
	endtask

	// one random request; returns 1 unless the kind is a no-op
	task automatic random_request(int grow_pct, int shrink_pct, output bit counted);
		int               roll;
		int               level;
		logic [2:0]       op;
		logic [IDX_W-1:0] idx;
		logic signed [DATA_W-1:0] val;
		level = shadow.fill;
		roll  = $urandom_range(0, 99);
		if (roll < 4)
			op = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		else if (roll < 4 + grow_pct)
			op = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
		else if (roll < 4 + grow_pct + shrink_pct)
			op = KIND_REMOVE;
		else
			op = ($urandom_range(0, 2) == 0) ? KIND_WRITE : KIND_READ;
		// level may trail by one request; it only steers the index choice
		roll = $urandom_range(0, 99);
		if (roll < 8 || op == KIND_APPEND)
			idx = IDX_W'($urandom_range(0, 127));
		else if (roll < 14)
			idx = IDX_W'(level);
		else if (roll < 18)
			idx = IDX_W'(level + 1);
		else if (op == KIND_INSERT)
			idx = IDX_W'($urandom_range(0, level));
		else
			idx = (level > 0) ? IDX_W'($urandom_range(0, level - 1)) : '0;
		case ($urandom_range(0, 19))
		0:       val = 32'sh8000_0000;
		1:       val = 32'sh7FFF_FFFF;
		2:       val = 32'sd0;
		3:       val = -32'sd1;
		default: val = $urandom;
		endcase
		issue(op, idx, val);
		counted = (op < KIND_UNUSED_FIRST);
	endtask

	initial begin
		int  done_items;
		int  block;
		int  in_block;
		int  grow_pct;
		int  shrink_pct;
		bit  idling_on;
		bit  counted;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle();

		done_items = 0;
		block      = 0;
		while (done_items < RANDOM_ITEMS) begin
			case (block % 4)
			0:       begin grow_pct = 60; shrink_pct = 15; end
			1:       begin grow_pct = 30; shrink_pct = 30; end
			2:       begin grow_pct = 12; shrink_pct = 64; end
			default: begin grow_pct = 78; shrink_pct = 8;  end
			endcase
			// no gaps in the last part of the run
			idling_on = (RANDOM_ITEMS - done_items > 2 * BLOCK_ITEMS) &&
				($urandom_range(0, 3) != 0);
			in_block = 0;
			while (in_block < BLOCK_ITEMS && done_items < RANDOM_ITEMS) begin
				if (idling_on && $urandom_range(0, 7) == 0)
					pause($urandom_range(1, 12));
				random_request(grow_pct, shrink_pct, counted);
				if (counted) begin
					in_block++;
					done_items++;
				end
			end
			// hold off until the block has delivered every result
			if (idling_on) settle();
			block++;
		end

		settle();
		repeat (4) @(posedge clk);
		$display("covered %0d results: read %0d write %0d insert %0d remove %0d append %0d noop %0d",
			shadow.results_seen, shadow.kind_hits[KIND_READ], shadow.kind_hits[KIND_WRITE],
			shadow.kind_hits[KIND_INSERT], shadow.kind_hits[KIND_REMOVE],
			shadow.kind_hits[KIND_APPEND],
			shadow.kind_hits[5] + shadow.kind_hits[6] + shadow.kind_hits[7]);
		$display("peak fill %0d of %0d, full rejects %0d, range rejects %0d, mismatches %0d",
			shadow.peak_fill, DEPTH, shadow.full_rejects, shadow.range_rejects, shadow.errors);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("indexed_insert_remove_array_unit regression: pass");
		else
			$display("indexed_insert_remove_array_unit regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/iira_pkg.sv
rtl/iira_cell.sv
rtl/indexed_insert_remove_array_unit.sv
test/indexed_insert_remove_array_unit_test.sv
